// ===== design/bsc_pkg.sv =====
package bsc_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int CMD_W    = 2;
    localparam int SYM_W    = 3;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PULL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // bracket codes: openers below closers, same kind order on both
    localparam logic [SYM_W-1:0] SYM_OPEN_LAST  = 3'd2;
    localparam logic [SYM_W-1:0] SYM_CLOSE_RND  = 3'd3;
    localparam logic [SYM_W-1:0] SYM_CLOSE_LAST = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic SIDE_BEFORE = 1'b0;
    localparam logic SIDE_AFTER  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture input beat
        logic exec;   // apply captured item, load output register
    } bsc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_stall;  // output register holds an untaken beat
    } bsc_stat_t;

endpackage

// ===== design/bracket_sequence_completer.sv =====
// Channel  Dir  Ports                      Contents
// s_       in   tvalid tready tdata tuser  tdata[2:0] symbol; tuser[1:0] command
// m_       out  tvalid tready tdata tuser  tdata[1:0] status, [4:2] out_symbol;
//               tlast                      tuser[0] out_valid, [1] out_side;
//                                          tlast done_res
//
// Each item has an accept cycle, during which both stack tops
// are read from their memories, then an execute cycle that compares against
// the registered top and updates counts, flags and the output register.
// One result beat per input beat. The execute cycle waits while an earlier
// result beat is still untaken; the next input is taken while a result waits.
// Reset clears counts, flags and handshake state; stack contents are
// undefined until pushed, so there is no clearing pass.
module bracket_sequence_completer
    import bsc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [2:0] symbol, rest zero fill
    input  logic [S_USER_W-1:0] s_tuser,   // [1:0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [1:0] status, [4:2] out_symbol
    output logic [M_USER_W-1:0] m_tuser,   // [0] out_valid, [1] out_side
    output logic                m_tlast    // done_res: completion finished
);

    bsc_cmd_t  cmd;
    bsc_stat_t stat;

    // sequencer: accept beat, then execute once output slot is free
    bsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // open/close stacks, counts, sticky flags, output register
    bsc_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ===== design/bsc_ctrl.sv =====
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bsc_stat_t stat,
    output bsc_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // stack tops were read during the accept cycle
                if (!stat.out_stall) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/bsc_dpath.sv =====
module bsc_dpath
    import bsc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [M_USER_W-1:0] m_tuser,
    output logic                m_tlast,
    input  bsc_cmd_t            cmd,
    output bsc_stat_t           stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    // stacks
    logic [KIND_W-1:0] open_mem  [DEPTH];
    logic [KIND_W-1:0] close_mem [DEPTH];
    logic [KIND_W-1:0] open_top_reg, close_top_reg;

    logic [CW-1:0] open_cnt_reg, open_cnt_next;
    logic [CW-1:0] close_cnt_reg, close_cnt_next;
    logic          mis_reg, mis_next;
    logic          ovf_reg, ovf_next;

    logic [CMD_W-1:0] cmd_reg;
    logic [SYM_W-1:0] sym_reg;

    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic              m_ovalid_reg, m_ovalid_next;
    logic [SYM_W-1:0]  m_sym_reg, m_sym_next;
    logic              m_side_reg, m_side_next;
    logic              m_done_reg, m_done_next;

    logic [CW-1:0] open_dec, close_dec;
    logic          open_we, close_we;
    logic [KIND_W-1:0] close_kind;
    logic          flagged;

    assign open_dec   = open_cnt_reg - CW'(1);
    assign close_dec  = close_cnt_reg - CW'(1);
    assign close_kind = KIND_W'(sym_reg - SYM_CLOSE_RND);
    assign flagged    = mis_reg | ovf_reg;

    assign stat.out_stall = m_valid_reg & ~m_tready;

    always_comb begin
        open_cnt_next  = open_cnt_reg;
        close_cnt_next = close_cnt_reg;
        mis_next       = mis_reg;
        ovf_next       = ovf_reg;
        open_we        = 1'b0;
        close_we       = 1'b0;
        m_ovalid_next  = 1'b0;
        m_sym_next     = '0;
        m_side_next    = SIDE_BEFORE;
        m_done_next    = 1'b0;
        case (cmd_reg)
            CMD_PUSH: begin
                if (!flagged) begin
                    if (sym_reg <= SYM_OPEN_LAST) begin
                        if (open_cnt_reg == FULL) begin
                            ovf_next = 1'b1;
                        end else begin
                            open_we       = 1'b1;
                            open_cnt_next = open_cnt_reg + CW'(1);
                        end
                    end else if (sym_reg <= SYM_CLOSE_LAST) begin
                        if (open_cnt_reg != '0) begin
                            open_cnt_next = open_dec;
                            if (open_top_reg != close_kind) begin
                                mis_next = 1'b1;
                            end
                        end else if (close_cnt_reg == FULL) begin
                            ovf_next = 1'b1;
                        end else begin
                            close_we       = 1'b1;
                            close_cnt_next = close_cnt_reg + CW'(1);
                        end
                    end
                end
            end
            CMD_PULL: begin
                if (!flagged) begin
                    if (close_cnt_reg != '0) begin
                        close_cnt_next = close_dec;
                        m_ovalid_next  = 1'b1;
                        m_sym_next     = SYM_W'(close_top_reg);
                        m_side_next    = SIDE_BEFORE;
                        m_done_next    = (close_dec == '0) && (open_cnt_reg == '0);
                    end else if (open_cnt_reg != '0) begin
                        open_cnt_next = open_dec;
                        m_ovalid_next = 1'b1;
                        m_sym_next    = SYM_W'(open_top_reg) + SYM_CLOSE_RND;
                        m_side_next   = SIDE_AFTER;
                        m_done_next   = (open_dec == '0);
                    end else begin
                        m_done_next = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                open_cnt_next  = '0;
                close_cnt_next = '0;
                mis_next       = 1'b0;
                ovf_next       = 1'b0;
            end
            default: begin
            end
        endcase
        if (mis_next) begin
            m_status_next = STAT_MISMATCH;
        end else if (ovf_next) begin
            m_status_next = STAT_OVERFLOW;
        end else begin
            m_status_next = STAT_OK;
        end
    end

    // stack memories: write on push, top read every cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec && open_we) begin
            open_mem[open_cnt_reg[AW-1:0]] <= sym_reg[KIND_W-1:0];
        end
        open_top_reg <= open_mem[open_dec[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && close_we) begin
            close_mem[close_cnt_reg[AW-1:0]] <= close_kind;
        end
        close_top_reg <= close_mem[close_dec[AW-1:0]];
    end

    // item capture and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= s_tuser[CMD_W-1:0];
            sym_reg <= s_tdata[SYM_W-1:0];
        end
        if (cmd.exec) begin
            m_status_reg <= m_status_next;
            m_ovalid_reg <= m_ovalid_next;
            m_sym_reg    <= m_sym_next;
            m_side_reg   <= m_side_next;
            m_done_reg   <= m_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_cnt_reg  <= '0;
            close_cnt_reg <= '0;
            mis_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.exec) begin
                open_cnt_reg  <= open_cnt_next;
                close_cnt_reg <= close_cnt_next;
                mis_reg       <= mis_next;
                ovf_reg       <= ovf_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - STAT_W - SYM_W)'(0), m_sym_reg, m_status_reg};
    assign m_tuser  = {m_side_reg, m_ovalid_reg};
    assign m_tlast  = m_done_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (open_cnt_reg <= FULL) && (close_cnt_reg <= FULL))
        else $error("stack count above depth");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mis_reg && ovf_reg))
        else $error("mismatch and overflow both set");

    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (!m_done_reg || (open_cnt_reg == '0 && close_cnt_reg == '0)))
        else $error("done reported with stacks not empty");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> ($stable(open_cnt_reg) && $stable(close_cnt_reg)))
        else $error("stack count moved without an executed item");

    a_no_exec_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && stat.out_stall))
        else $error("result overwritten before taken");

endmodule

// ===== tb/bsc_checker.sv =====
module bsc_checker
    import bsc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [2:0] symbol, rest zero fill
    input  logic [S_USER_W-1:0] s_tuser,   // [1:0] command
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // [1:0] status, [4:2] out_symbol
    input  logic [M_USER_W-1:0] m_tuser,   // [0] out_valid, [1] out_side
    input  logic                m_tlast,   // done_res
    output int                  error_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              valid;
        logic [SYM_W-1:0]  sym;
        logic              side;
        logic              done;
    } completion_t;

    completion_t       completion_q[$];
    completion_t       want;
    logic [KIND_W-1:0] open_kinds  [DEPTH];
    logic [KIND_W-1:0] close_kinds [DEPTH];
    int                open_depth;
    int                close_depth;
    logic              mismatch_seen;
    logic              overflow_seen;
    int                beat_idx;

    function automatic logic [STAT_W-1:0] fragment_status();
        if (mismatch_seen) return STAT_MISMATCH;
        if (overflow_seen) return STAT_OVERFLOW;
        return STAT_OK;
    endfunction

    // advance the fragment state by one input beat, return the result it produces
    function automatic completion_t next_completion(input logic [CMD_W-1:0] cmd,
                                                    input logic [SYM_W-1:0] sym);
        completion_t       res;
        logic [KIND_W-1:0] kind;
        res = '0;
        if (cmd == CMD_PUSH) begin
            if (!mismatch_seen && !overflow_seen) begin
                if (sym <= SYM_OPEN_LAST) begin
                    if (open_depth >= DEPTH) begin
                        overflow_seen = 1'b1;
                    end else begin
                        open_kinds[open_depth] = KIND_W'(sym);
                        open_depth++;
                    end
                end else if (sym <= SYM_CLOSE_LAST) begin
                    kind = KIND_W'(sym - SYM_CLOSE_RND);
                    if (open_depth > 0) begin
                        open_depth--;
                        if (open_kinds[open_depth] != kind) mismatch_seen = 1'b1;
                    end else if (close_depth >= DEPTH) begin
                        overflow_seen = 1'b1;
                    end else begin
                        close_kinds[close_depth] = kind;
                        close_depth++;
                    end
                end
            end
        end else if (cmd == CMD_PULL) begin
            if (!mismatch_seen && !overflow_seen) begin
                if (close_depth > 0) begin
                    close_depth--;
                    res.sym   = SYM_W'(close_kinds[close_depth]);
                    res.valid = 1'b1;
                    res.side  = SIDE_BEFORE;
                end else if (open_depth > 0) begin
                    open_depth--;
                    res.sym   = SYM_W'(open_kinds[open_depth]) + SYM_CLOSE_RND;
                    res.valid = 1'b1;
                    res.side  = SIDE_AFTER;
                end
                res.done = (close_depth == 0) && (open_depth == 0);
            end
        end else if (cmd == CMD_CLEAR) begin
            open_depth    = 0;
            close_depth   = 0;
            mismatch_seen = 1'b0;
            overflow_seen = 1'b0;
        end
        res.status = fragment_status();
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
        if (got !== exp_val) begin
            $display("%0t: beat %0d %s mismatch, expected %0d, actual %0d",
                     $time, beat_idx, name, exp_val, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            completion_q.delete();
            open_depth    = 0;
            close_depth   = 0;
            mismatch_seen = 1'b0;
            overflow_seen = 1'b0;
            beat_idx      = 0;
        end else begin
            // result first: it can never belong to a beat taken at this same edge
            if (m_tvalid && m_tready) begin
                if (completion_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h/%h/%b",
                             $time, m_tdata, m_tuser, m_tlast);
                    error_count++;
                end else begin
                    want = completion_q.pop_front();
                    check_field("status", 8'(m_tdata[STAT_W-1:0]), 8'(want.status));
                    check_field("out_valid", 8'(m_tuser[0]), 8'(want.valid));
                    check_field("out_symbol", 8'(m_tdata[STAT_W+SYM_W-1:STAT_W]),
                                8'(want.sym));
                    check_field("out_side", 8'(m_tuser[1]), 8'(want.side));
                    check_field("done_res", 8'(m_tlast), 8'(want.done));
                end
                beat_idx++;
            end
            if (s_tvalid && s_tready)
                completion_q.push_back(next_completion(s_tuser[CMD_W-1:0],
                                                       s_tdata[SYM_W-1:0]));
        end
        pending = completion_q.size();
    end

endmodule

// ===== tb/tb_bracket_sequence_completer.sv =====
module tb_bracket_sequence_completer;
    timeunit 1ns;
    timeprecision 1ps;
    import bsc_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_TAIL    = 60;      // last random beats with no idling
    localparam int LONG_HOLD    = 400;     // receiver hold-off, cycles
    localparam int DEEP_PULLS   = 16;      // pulls from a full closer stack
    localparam int DRAIN_CYCLES = 20;      // settle time after the last result
    localparam int CYCLE_LIMIT  = 600000;
    localparam int NUM_KINDS    = 3;

    // command code the block does not use
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // bracket codes
    localparam logic [SYM_W-1:0] SYM_RND_OPEN  = 3'd0;
    localparam logic [SYM_W-1:0] SYM_SQR_OPEN  = 3'd1;
    localparam logic [SYM_W-1:0] SYM_CRL_OPEN  = 3'd2;
    localparam logic [SYM_W-1:0] SYM_RND_CLOSE = 3'd3;
    localparam logic [SYM_W-1:0] SYM_SQR_CLOSE = 3'd4;
    localparam logic [SYM_W-1:0] SYM_CRL_CLOSE = 3'd5;
    localparam logic [SYM_W-1:0] SYM_BAD_LO    = 3'd6;
    localparam logic [SYM_W-1:0] SYM_BAD_HI    = 3'd7;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [2:0] symbol, rest zero fill
    logic [S_USER_W-1:0] s_tuser;   // [1:0] command
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [1:0] status, [4:2] out_symbol
    logic [M_USER_W-1:0] m_tuser;   // [0] out_valid, [1] out_side
    logic                m_tlast;   // done_res

    int   fail_count;
    int   pending;
    logic s_taken = 1'b0;       // input beat went through at the last rising edge
    logic no_idle = 1'b0;       // both sides run flat out
    logic hold_req = 1'b0;      // ask the receiver for one long hold-off
    logic hold_served = 1'b0;

    // Rough copy of the fragment, kept only to steer the generator toward
    // matching closers and full-length completions.
    logic [KIND_W-1:0] open_shadow[$];
    int                close_shadow;
    logic              frag_broken;
    int                useful_beats;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bracket_sequence_completer #(.DEPTH(DEPTH)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bsc_checker #(.DEPTH(DEPTH)) u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .error_count (fail_count),
        .pending     (pending)
    );

    // Sampled with the pre-edge values, so the sender can look at it at the
    // following falling edge without racing the block.
    always @(posedge aclk) s_taken <= s_tvalid && s_tready;

    // Offer one beat from a falling edge and return at the falling edge after
    // it was taken. An optional idle burst goes in front of it.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym);
        logic useful;
        int   top_kind;
        useful = (cmd == CMD_PULL) || (cmd == CMD_CLEAR) ||
                 (cmd == CMD_PUSH && !frag_broken && sym <= SYM_CLOSE_LAST);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= S_USER_W'(cmd);
        s_tdata  <= S_DATA_W'(sym);
        do @(negedge aclk); while (!s_taken);

        // keep the generator's view of the fragment in step
        if (cmd == CMD_PUSH && !frag_broken) begin
            if (sym <= SYM_OPEN_LAST) begin
                if (open_shadow.size() >= DEPTH) frag_broken = 1'b1;
                else open_shadow.push_back(KIND_W'(sym));
            end else if (sym <= SYM_CLOSE_LAST) begin
                if (open_shadow.size() > 0) begin
                    top_kind = open_shadow.pop_back();
                    if (top_kind != int'(sym - SYM_CLOSE_RND)) frag_broken = 1'b1;
                end else if (close_shadow >= DEPTH) begin
                    frag_broken = 1'b1;
                end else begin
                    close_shadow++;
                end
            end
        end else if (cmd == CMD_PULL && !frag_broken) begin
            if (close_shadow > 0) close_shadow--;
            else if (open_shadow.size() > 0) void'(open_shadow.pop_back());
        end else if (cmd == CMD_CLEAR) begin
            open_shadow.delete();
            close_shadow = 0;
            frag_broken  = 1'b0;
        end
        if (useful) useful_beats++;
    endtask

    // Sender stops and waits for every outstanding result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
    endtask

    // One random action, mostly pushes that keep the fragment well formed.
    task automatic random_step();
        int               r;
        int               n;
        int               top_kind;
        logic [SYM_W-1:0] sym;
        r = $urandom_range(0, 99);
        if (frag_broken && r < 40) begin
            send_item(CMD_CLEAR, SYM_W'($urandom));
        end else if (r < 3) begin
            send_item(CMD_CLEAR, SYM_W'($urandom));
        end else if (r < 5) begin
            send_item(CMD_UNUSED, SYM_W'($urandom));
        end else if (r < 7) begin
            send_item(CMD_PUSH, SYM_W'($urandom_range(SYM_BAD_LO, SYM_BAD_HI)));
        end else if (r < 22) begin
            send_item(CMD_PULL, SYM_W'($urandom));
        end else if (r < 25) begin
            // whole completion, then one more pull on the empty fragment
            n = close_shadow + open_shadow.size();
            repeat (n + 1) send_item(CMD_PULL, SYM_W'($urandom));
        end else begin
            if (open_shadow.size() > 0 && $urandom_range(0, 9) < 5) begin
                top_kind = open_shadow[$];
                if ($urandom_range(0, 39) == 0)
                    sym = SYM_CLOSE_RND + SYM_W'((top_kind + 1) % NUM_KINDS);
                else
                    sym = SYM_CLOSE_RND + SYM_W'(top_kind);
            end else if ($urandom_range(0, 2) == 0) begin
                sym = SYM_W'($urandom_range(SYM_CLOSE_RND, SYM_CLOSE_LAST));
            end else begin
                sym = SYM_W'($urandom_range(SYM_RND_OPEN, SYM_OPEN_LAST));
            end
            send_item(CMD_PUSH, sym);
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request, and
    // always ready once the run goes calm.
    initial begin : receiver
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_served) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_served = 1'b1;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, CYCLE_LIMIT, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        close_shadow = 0;
        frag_broken  = 1'b0;
        useful_beats = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed ---
        send_item(CMD_PULL, SYM_RND_OPEN);      // empty fragment: done, nothing out
        send_item(CMD_PUSH, SYM_RND_OPEN);
        send_item(CMD_PUSH, SYM_SQR_CLOSE);     // wrong kind on top -> mismatch
        send_item(CMD_PUSH, SYM_SQR_OPEN);      // ignored while flagged
        send_item(CMD_PULL, SYM_BAD_HI);        // flagged: nothing emitted
        send_item(CMD_CLEAR, SYM_BAD_HI);
        send_item(CMD_PUSH, SYM_CRL_CLOSE);     // no opener waits -> closer stack
        send_item(CMD_PUSH, SYM_RND_CLOSE);
        send_item(CMD_PUSH, SYM_CRL_OPEN);
        send_item(CMD_PUSH, SYM_SQR_OPEN);
        send_item(CMD_PUSH, SYM_SQR_CLOSE);     // matching pop
        send_item(CMD_PUSH, SYM_BAD_LO);        // undefined codes do nothing
        send_item(CMD_PUSH, SYM_BAD_HI);
        send_item(CMD_UNUSED, SYM_CRL_CLOSE);   // status only
        send_item(CMD_PULL, SYM_RND_OPEN);      // '(' before
        send_item(CMD_PUSH, SYM_RND_OPEN);      // push between pulls
        send_item(CMD_PULL, SYM_RND_OPEN);      // '{' before
        send_item(CMD_PULL, SYM_RND_OPEN);      // ')' after
        send_item(CMD_PULL, SYM_RND_OPEN);      // '}' after, last one
        send_item(CMD_PULL, SYM_RND_OPEN);      // already empty
        send_item(CMD_CLEAR, SYM_RND_OPEN);
        send_item(CMD_PUSH, SYM_CRL_OPEN);
        send_item(CMD_PUSH, SYM_RND_CLOSE);     // mismatch
        send_item(CMD_UNUSED, SYM_RND_OPEN);    // reports the flag
        send_item(CMD_CLEAR, SYM_RND_OPEN);
        wait_drained();

        // --- open stack to the brim and past it, with the receiver holding off
        // so the block backs up onto its input ---
        hold_req = 1'b1;
        repeat (DEPTH)
            send_item(CMD_PUSH, SYM_W'($urandom_range(SYM_RND_OPEN, SYM_OPEN_LAST)));
        // overflow
        send_item(CMD_PUSH, SYM_W'($urandom_range(SYM_RND_OPEN, SYM_OPEN_LAST)));
        send_item(CMD_PULL, SYM_W'($urandom));
        send_item(CMD_CLEAR, SYM_W'($urandom));
        wait_drained();

        // --- closer stack: fill, pull a few deep entries, refill, overflow ---
        repeat (DEPTH)
            send_item(CMD_PUSH, SYM_W'($urandom_range(SYM_CLOSE_RND, SYM_CLOSE_LAST)));
        repeat (DEEP_PULLS) send_item(CMD_PULL, SYM_W'($urandom));
        repeat (DEEP_PULLS)
            send_item(CMD_PUSH, SYM_W'($urandom_range(SYM_CLOSE_RND, SYM_CLOSE_LAST)));
        send_item(CMD_PUSH, SYM_CRL_CLOSE);     // overflow
        send_item(CMD_PUSH, SYM_RND_OPEN);      // ignored
        send_item(CMD_PULL, SYM_W'($urandom));
        send_item(CMD_CLEAR, SYM_W'($urandom));
        wait_drained();

        // --- random fragments; a calm stretch in the middle and at the end ---
        useful_beats = 0;
        while (useful_beats < RANDOM_ITEMS) begin
            no_idle = (useful_beats >= RANDOM_ITEMS - CALM_TAIL) ||
                      ((useful_beats / 50) % 4 == 2);
            random_step();
            if ($urandom_range(0, 199) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
